FILE: src/plst_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types for the positional list store
package plst_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int MODE_W         = 3;
  localparam int STATUS_W       = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } state_t;

  // broadcast command seen by every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
    logic wr;
  } cell_cmd_t;

endpackage

FILE: src/plst_cell.sv
`timescale 1ns / 1ps
// one storage cell of the list row, shifting to either neighbour
module plst_cell
  import plst_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int CNT_W      = 5,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [CNT_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && (MY_POS > pos)) begin
      data_nxt = left_data;
    end else if (cmd.ins && (MY_POS == pos)) begin
      data_nxt = wr_data;
    end else if (cmd.del && (MY_POS >= pos)) begin
      data_nxt = right_data;
    end else if (cmd.wr && (MY_POS == pos)) begin
      data_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: src/positional_list_store_top.sv
`timescale 1ns / 1ps
// top level of the positional list store: command decode, cell row and result register
//
// usage
//   a request is taken at a rising edge with start high and busy low; it carries
//   in_mode (insert, delete, replace, retrieve, traverse), in_position and in_value
//   the list lives in a row of CAPACITY cells; insert shifts the cells at and
//   behind the position back by one, delete pulls them forward by one, all in
//   the same cycle; every result appears on the out_ ports for exactly one cycle
//   with out_valid high, and the first result of a request is registered in the
//   cycle after it is taken; out_count is the count after the request
//   and out_last marks the final result of that request
//   traverse gives one result per entry, one per cycle, read from the row by a
//   position counter; busy stays high until the walk reaches the last entry,
//   and the next request can follow the last one
//   the receiver cannot stall: results are never held back
//   reset (rst_n low, synchronous) empties the list and drops any traverse in
//   progress; cell contents are not cleared, cells past the count are never read
module positional_list_store_top
  import plst_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(CAPACITY + 1),
  parameter int IDX_W      = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [CNT_W-1:0]      in_position,
  input  logic [DATA_WIDTH-1:0] in_value,
  // result channel
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_value_out,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]      out_count,
  output logic                  out_last
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;

  // request decode
  logic accept;
  logic is_ins, is_del, is_rep, is_ret, is_trav;
  logic list_full, list_empty;
  logic ins_ok, pos_in_list;
  logic trav_last;
  cell_cmd_t cmd;

  // cell row
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rd_data;

  assign busy   = (state_r == ST_TRAV);
  assign accept = start && !busy;

  assign is_ins  = (in_mode == MODE_INSERT);
  assign is_del  = (in_mode == MODE_DELETE);
  assign is_rep  = (in_mode == MODE_REPLACE);
  assign is_ret  = (in_mode == MODE_RETRIEVE);
  assign is_trav = (in_mode == MODE_TRAVERSE);

  assign list_full   = (count_r == CAP_CNT);
  assign list_empty  = (count_r == '0);
  // insert may append at the tail, the others need an existing entry
  assign ins_ok      = !list_full && (in_position <= count_r);
  assign pos_in_list = !list_empty && (in_position < count_r);

  assign cmd.ins = accept && is_ins && ins_ok;
  assign cmd.del = accept && is_del && pos_in_list;
  assign cmd.wr  = accept && is_rep && pos_in_list;

  // final entry of a traverse walk
  assign trav_last = (CNT_W'(idx_r) == (count_r - ONE_CNT));

  // one read port on the row: walk counter, head for a new traverse, else position
  always_comb begin
    if (busy) begin
      rd_idx = idx_r;
    end else if (is_trav) begin
      rd_idx = '0;
    end else begin
      rd_idx = in_position[IDX_W-1:0];
    end
  end

  assign rd_data = cell_q[rd_idx];

  // row of cells, each shifting to or from its neighbours
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (gi == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_body_l
      assign left_d = cell_q[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body_r
      assign right_d = cell_q[gi+1];
    end

    plst_cell #(
      .INDEX      (gi),
      .CNT_W      (CNT_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (in_position),
      .wr_data    (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[gi])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_trav && (count_r > ONE_CNT)) begin
          state_nxt = ST_TRAV;
        end
      end
      ST_TRAV: begin
        if (trav_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs, count and walk counter
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STATUS_OK;
    out_count_nxt  = count_r;
    out_last_nxt   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (cmd.ins) begin
            count_nxt = count_r + ONE_CNT;
          end else if (cmd.del) begin
            count_nxt = count_r - ONE_CNT;
          end
          out_count_nxt = count_nxt;
          if (is_ins) begin
            if (list_full) begin
              out_status_nxt = STATUS_FULL;
            end else if (!ins_ok) begin
              out_status_nxt = STATUS_RANGE;
            end
          end else if (is_del || is_rep || is_ret) begin
            if (list_empty) begin
              out_status_nxt = STATUS_EMPTY;
            end else if (!pos_in_list) begin
              out_status_nxt = STATUS_RANGE;
            end else if (!is_rep) begin
              out_value_nxt = rd_data;
            end
          end else if (is_trav) begin
            if (list_empty) begin
              out_status_nxt = STATUS_EMPTY;
            end else begin
              out_value_nxt = rd_data;
              out_last_nxt  = (count_r == ONE_CNT);
              idx_nxt       = IDX_W'(1);
            end
          end
        end
      end
      ST_TRAV: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data;
        out_last_nxt  = trav_last;
        idx_nxt       = idx_r + 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, qualified by the strobe
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;

  // a final result always leaves the block free for the next request
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy still high after a final result");

  // an unfinished traverse keeps the block busy
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("traverse result without final mark while idle");

  // every busy cycle produces one traverse result
  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("traverse cycle without a result");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count beyond capacity");

  // only insert and delete move the count
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && (is_ins || is_del)) |=> $stable(count_r))
    else $error("entry count changed without insert or delete");

endmodule

FILE: sim/positional_list_store_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the positional list store top level
module positional_list_store_top_tb;
  import plst_pkg::*;

  localparam int CAP      = CAPACITY_DEF;
  localparam int DW       = DATA_WIDTH_DEF;
  localparam int CNT_W    = $clog2(CAP + 1);
  localparam int LIMIT    = 200000;
  localparam int TAIL     = 20;
  // modes the block does not decode, answered with a plain ok
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DW-1:0]       value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
    logic                last;
  } list_result_t;

  // tracks the list contents and the results each request should produce
  class list_tracker;
    logic [DW-1:0]    cells [CAP];
    int unsigned      fill;
    list_result_t     awaited [$];
    int               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void expect_result(logic [DW-1:0] v, logic [STATUS_W-1:0] st, logic fin);
      list_result_t r;
      r.value  = v;
      r.status = st;
      r.count  = CNT_W'(fill);
      r.last   = fin;
      awaited.push_back(r);
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] pos,
                               logic [DW-1:0] val);
      logic [DW-1:0]       got;
      logic [STATUS_W-1:0] st;
      int unsigned         p;
      got = '0;
      st  = STATUS_OK;
      p   = pos;
      case (mode)
        MODE_INSERT: begin
          if (fill >= CAP) st = STATUS_FULL;
          else if (p > fill) st = STATUS_RANGE;
          else begin
            for (int i = fill; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val;
            fill++;
          end
        end
        MODE_DELETE, MODE_REPLACE, MODE_RETRIEVE: begin
          if (fill == 0) st = STATUS_EMPTY;
          else if (p >= fill) st = STATUS_RANGE;
          else if (mode == MODE_DELETE) begin
            got = cells[p];
            for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end else if (mode == MODE_REPLACE) cells[p] = val;
          else got = cells[p];
        end
        MODE_TRAVERSE: begin
          if (fill == 0) expect_result('0, STATUS_EMPTY, 1'b1);
          else for (int i = 0; i < fill; i++) expect_result(cells[i], STATUS_OK, i + 1 == fill);
          return;
        end
        default: ;
      endcase
      expect_result(got, st, 1'b1);
    endfunction

    function void check_result(list_result_t seen);
      list_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result: value %h status %0d count %0d last %0d",
                 $time, seen.value, seen.status, seen.count, seen.last);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (seen !== want) begin
          $display("%0t result mismatch: expected value %h status %0d count %0d last %0d",
                   $time, want.value, want.status, want.count, want.last);
          $display("%0t                  actual   value %h status %0d count %0d last %0d",
                   $time, seen.value, seen.status, seen.count, seen.last);
          errors++;
        end
      end
    endfunction

    function bit drained();
      return awaited.size() == 0;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic [MODE_W-1:0]     in_mode     = '0;
  logic [CNT_W-1:0]      in_position = '0;
  logic [DW-1:0]         in_value    = '0;
  logic                  busy;
  logic                  out_valid;
  logic [DW-1:0]         out_value_out;
  logic [STATUS_W-1:0]   out_status;
  logic [CNT_W-1:0]      out_count;
  logic                  out_last;

  list_tracker sb = new();
  int unsigned cycles = 0;
  bit          grow   = 1'b1;

  positional_list_store_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_value_out, out_status, out_count, out_last});
  end

  // watchdog against a hung handshake or missing results
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, sb.awaited.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one request and hold it until taken (start high, busy low at an edge)
  task automatic send(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] pos, logic [DW-1:0] val);
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= val;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(mode, pos, val);
  endtask

  // drop start and hold off until every outstanding result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (!sb.drained());
  endtask

  // random gap after a request, given as a percentage of requests
  task automatic maybe_idle(int idle_pct);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly well-formed requests, swinging the list between empty and full
  task automatic random_requests(int n, int idle_pct);
    int                  r;
    int unsigned         f;
    logic [MODE_W-1:0]   mode;
    logic [CNT_W-1:0]    pos;
    logic [DW-1:0]       val;
    for (int k = 0; k < n; k++) begin
      f = sb.fill;
      if (f == CAP) grow = 1'b0;
      else if (f == 0) grow = 1'b1;
      else if ($urandom_range(29) == 0) grow = !grow;
      r = $urandom_range(99);
      if (r < (grow ? 45 : 20)) mode = MODE_INSERT;
      else if (r < 60) mode = MODE_DELETE;
      else if (r < 72) mode = MODE_REPLACE;
      else if (r < 84) mode = MODE_RETRIEVE;
      else if (r < 96) mode = MODE_TRAVERSE;
      else mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      // occasional stray position anywhere in the field
      if ($urandom_range(9) == 0) pos = CNT_W'($urandom_range(31));
      else if (mode == MODE_INSERT) pos = CNT_W'($urandom_range(f));
      else pos = (f == 0) ? '0 : CNT_W'($urandom_range(f - 1));
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      send(mode, pos, val);
      maybe_idle(idle_pct);
    end
  endtask

  initial begin
    // synchronous reset held low at the start
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every operation flagged or answered with the empty status
    send(MODE_TRAVERSE, '0, '0);
    send(MODE_DELETE, '0, '0);
    send(MODE_REPLACE, '0, 32'hdead_beef);
    send(MODE_RETRIEVE, 5'd31, '0);
    send(MODE_INSERT, 5'd1, 32'h1234_5678);
    // spare modes do nothing but report ok
    send(MODE_SPARE_LO, 5'd31, '1);
    send(MODE_SPARE_HI, 5'd0, '1);
    // value extremes, insert at front, replace, range check at count
    send(MODE_INSERT, 5'd0, '0);
    send(MODE_INSERT, 5'd0, '1);
    send(MODE_RETRIEVE, 5'd1, '0);
    send(MODE_REPLACE, 5'd0, 32'ha5a5_5a5a);
    send(MODE_DELETE, 5'd2, '0);
    send(MODE_DELETE, 5'd0, '0);
    send(MODE_TRAVERSE, 5'd31, '1);
    // fill to capacity at scattered positions
    while (sb.fill < CAP) send(MODE_INSERT, CNT_W'($urandom_range(sb.fill)), $urandom);
    // full list: full status wins over the out of range position
    send(MODE_INSERT, 5'd31, '1);
    send(MODE_TRAVERSE, '0, '0);
    send(MODE_DELETE, CNT_W'(CAP - 1), '0);

    // sender waits for every outstanding result before the random part
    drain();

    // phase with no idling, then heavy and light sender gaps
    random_requests(100, 0);
    drain();
    random_requests(110, 46);
    drain();
    random_requests(100, 14);
    drain();

    // allow for any stray late results
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.drained()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/plst_pkg.sv
src/plst_cell.sv
src/positional_list_store_top.sv
sim/positional_list_store_top_tb.sv
